### src/register_machine_execute_unit_defines.svh
// ----------------------------------------------------------------------------
// register machine execute unit: assertion macros
// shared property wrappers clocked on clk, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// property checked only outside reset
`define RME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define RME_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// shared types and codes of the register machine execute unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rme_pkg;

  // register and operand width
  localparam int DATA_WIDTH = 32;
  // register index field width
  localparam int REG_IDX_W  = 5;

  // instruction codes
  typedef enum logic [3:0] {
    ACT_MOV  = 4'd0,
    ACT_INC  = 4'd1,
    ACT_DEC  = 4'd2,
    ACT_ADD  = 4'd3,
    ACT_SUB  = 4'd4,
    ACT_MUL  = 4'd5,
    ACT_DIV  = 4'd6,
    ACT_CMP  = 4'd7,
    ACT_JMP  = 4'd8,
    ACT_JNE  = 4'd9,
    ACT_JE   = 4'd10,
    ACT_JGE  = 4'd11,
    ACT_JG   = 4'd12,
    ACT_JLE  = 4'd13,
    ACT_JL   = 4'd14,
    ACT_READ = 4'd15
  } action_t;

  // last compare outcome
  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_LT = 2'd2;

  // input word
  typedef struct packed {
    logic [3:0]           action;
    logic [REG_IDX_W-1:0] dest_reg;
    logic                 src_is_reg;
    logic [REG_IDX_W-1:0] src_reg;
    logic signed [31:0]   immediate;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dest_value;
    logic                         branch_taken;
    logic                         divide_error;
  } out_word_t;

endpackage

`default_nettype wire

### src/rme_regfile.sv
// ----------------------------------------------------------------------------
// rme_regfile
// register file memory, one write port and two registered read ports,
// with a per-entry valid bit so that unwritten registers read as zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rme_regfile import rme_pkg::*; #(
  parameter int NUM_REGS = 26,
  parameter int AW       = $clog2(NUM_REGS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr_a,
  input  logic [AW-1:0]         rd_addr_b,
  output logic [DATA_WIDTH-1:0] rd_data_a,
  output logic [DATA_WIDTH-1:0] rd_data_b,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data
);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   valid;
  logic [DATA_WIDTH-1:0] data_a;
  logic [DATA_WIDTH-1:0] data_b;
  logic                  vld_a;
  logic                  vld_b;

  // written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a <= mem[rd_addr_a];
      data_b <= mem[rd_addr_b];
      vld_a  <= valid[rd_addr_a];
      vld_b  <= valid[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a ? data_a : '0;
  assign rd_data_b = vld_b ? data_b : '0;

endmodule

`default_nettype wire

### src/rme_divider.sv
// ----------------------------------------------------------------------------
// rme_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rme_divider import rme_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH:0]   rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] dvs;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic [DATA_WIDTH:0]   rem_next;
  logic [DATA_WIDTH-1:0] quo_next;

  // one shift-subtract step
  always_comb begin
    shifted = {rem[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    if (!diff[DATA_WIDTH+1]) begin
      rem_next = diff[DATA_WIDTH:0];
      quo_next = {quo[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_next = shifted;
      quo_next = {quo[DATA_WIDTH-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_WIDTH);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

### src/register_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// executes one decoded instruction per input word on a register file
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. A word accepted on the input starts
// the registered read of both operands from the register file memory. In
// S_READ the result is computed and registered; in S_WB it is written back
// together with loading the result register, once that register is free.
// A div with a nonzero divisor first runs through the bit-serial divider in
// S_DIV over 32 quotient-bit steps. The result register lets the next word be
// accepted while a finished result still waits on out_ready. Registers read
// as zero until written, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module register_machine_execute_unit import rme_pkg::*; #(
  parameter int NUM_REGS = 26
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = $clog2(NUM_REGS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_WB
  } state_t;

  state_t                state;
  in_word_t              item;
  logic                  dst_ok;
  logic                  src_ok;
  logic [1:0]            cmp_result;
  logic [1:0]            cmp_next;
  logic [DATA_WIDTH-1:0] res;
  logic [DATA_WIDTH-1:0] res_next;
  logic                  taken;
  logic                  taken_next;
  logic                  derr;
  logic                  derr_next;
  logic                  do_write;
  logic                  do_write_next;
  logic                  div_neg;
  logic                  div_start;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_quo;
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic [DATA_WIDTH-1:0] op_a;
  logic [DATA_WIDTH-1:0] op_b;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic                  accept;
  logic                  out_free;
  logic                  wr_en;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign wr_en    = (state == S_WB) && out_free && do_write && dst_ok;

  // register file memory
  rme_regfile #(
    .NUM_REGS (NUM_REGS),
    .AW       (AW)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (AW'(in_data.dest_reg)),
    .rd_addr_b (AW'(in_data.src_reg)),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr_en     (wr_en),
    .wr_addr   (AW'(item.dest_reg)),
    .wr_data   (res)
  );

  // operand selection, out-of-range registers read as zero
  always_comb begin
    op_a  = dst_ok ? rd_a : '0;
    if (item.src_is_reg) begin
      op_b = src_ok ? rd_b : '0;
    end else begin
      op_b = DATA_WIDTH'(item.immediate);
    end
    mag_a = op_a[DATA_WIDTH-1] ? -op_a : op_a;
    mag_b = op_b[DATA_WIDTH-1] ? -op_b : op_b;
  end

  assign div_start = (state == S_READ) && (action_t'(item.action) == ACT_DIV) &&
                     (op_b != '0);

  // signed three-way compare of the operands
  always_comb begin
    if (op_a == op_b) begin
      cmp_next = CMP_EQ;
    end else if ($signed(op_a) > $signed(op_b)) begin
      cmp_next = CMP_GT;
    end else begin
      cmp_next = CMP_LT;
    end
  end

  // execute datapath for the held word
  always_comb begin
    res_next      = op_a;
    taken_next    = 1'b0;
    derr_next     = 1'b0;
    do_write_next = 1'b0;
    case (action_t'(item.action))
      ACT_MOV: begin
        res_next      = op_b;
        do_write_next = 1'b1;
      end
      ACT_INC: begin
        res_next      = op_a + 1'b1;
        do_write_next = 1'b1;
      end
      ACT_DEC: begin
        res_next      = op_a - 1'b1;
        do_write_next = 1'b1;
      end
      ACT_ADD: begin
        res_next      = op_a + op_b;
        do_write_next = 1'b1;
      end
      ACT_SUB: begin
        res_next      = op_a - op_b;
        do_write_next = 1'b1;
      end
      ACT_MUL: begin
        res_next      = op_a * op_b;
        do_write_next = 1'b1;
      end
      ACT_DIV: begin
        if (op_b == '0) begin
          derr_next = 1'b1;
        end else begin
          do_write_next = 1'b1;
        end
      end
      ACT_JMP: begin
        res_next   = '0;
        taken_next = 1'b1;
      end
      ACT_JNE: begin
        res_next   = '0;
        taken_next = (cmp_result != CMP_EQ);
      end
      ACT_JE: begin
        res_next   = '0;
        taken_next = (cmp_result == CMP_EQ);
      end
      ACT_JGE: begin
        res_next   = '0;
        taken_next = (cmp_result == CMP_EQ) || (cmp_result == CMP_GT);
      end
      ACT_JG: begin
        res_next   = '0;
        taken_next = (cmp_result == CMP_GT);
      end
      ACT_JLE: begin
        res_next   = '0;
        taken_next = (cmp_result != CMP_GT);
      end
      ACT_JL: begin
        res_next   = '0;
        taken_next = (cmp_result != CMP_EQ) && (cmp_result != CMP_GT);
      end
      default: begin
        res_next = op_a;
      end
    endcase
  end

  // single iterative divider on magnitudes
  rme_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cmp_result <= CMP_EQ;
      out_valid  <= 1'b0;
    end else begin
      if ((state == S_WB) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item   <= in_data;
            dst_ok <= int'(in_data.dest_reg) < NUM_REGS;
            src_ok <= int'(in_data.src_reg) < NUM_REGS;
            state  <= S_READ;
          end
        end
        S_READ: begin
          res      <= res_next;
          taken    <= taken_next;
          derr     <= derr_next;
          do_write <= do_write_next;
          div_neg  <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
          if (action_t'(item.action) == ACT_CMP) begin
            cmp_result <= cmp_next;
          end
          state <= div_start ? S_DIV : S_WB;
        end
        S_DIV: begin
          if (div_done) begin
            res   <= div_neg ? -div_quo : div_quo;
            state <= S_WB;
          end
        end
        S_WB: begin
          if (out_free) begin
            out_data.dest_value   <= dst_ok ? res : '0;
            out_data.branch_taken <= taken;
            out_data.divide_error <= derr;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_checker
// port-level checks of the register machine execute unit, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "register_machine_execute_unit_defines.svh"

module rme_checker import rme_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a stalled result word holds
  `RME_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")

  // one instruction at a time: busy right after an accept
  `RME_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "input accepted while an instruction is in flight")

  // a taken jump never reports a value or a divide error
  `RME_ASSERT(a_jump_clean, out_valid && out_data.branch_taken |-> out_data.dest_value == '0 && !out_data.divide_error, "taken jump carries value or divide error")

  // no result right after reset
  `RME_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result valid right after reset")

endmodule

bind register_machine_execute_unit rme_checker u_rme_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### verif/register_machine_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// register_machine_execute_unit_tb
// Runs decoded instructions through the execute unit and checks each result
// word against a shadow register file and last-compare state kept here.
// A directed opening covers wrap, divide and compare corners; random traffic
// follows, with idle bursts on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module register_machine_execute_unit_tb;
  import rme_pkg::*;

  localparam int NUM_REGS     = 26;
  localparam int RANDOM_WORDS = 340;
  localparam int CALM_TAIL    = 50;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 50;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic     drain_first;
    in_word_t word;
  } instr_slot_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // shadow machine state
  logic [31:0] arch_regs [NUM_REGS];
  logic [1:0]  arch_cmp;

  instr_slot_t instr_queue [$];
  out_word_t   pending_results [$];

  int   words_in = 0;
  int   total_words = 0;
  int   errors = 0;
  int   cycles = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic word_taken = 1'b0;
  logic calm;

  assign calm = (words_in + CALM_TAIL >= total_words);

  register_machine_execute_unit #(.NUM_REGS(NUM_REGS)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // shadow register access, out-of-range indexes read zero and drop writes
  function automatic logic [31:0] reg_read(input logic [4:0] idx);
    return (idx < NUM_REGS) ? arch_regs[idx] : 32'd0;
  endfunction

  function automatic void reg_write(input logic [4:0] idx, input logic [31:0] val);
    if (idx < NUM_REGS) arch_regs[idx] = val;
  endfunction

  // execute one instruction on the shadow state and return its result word
  function automatic out_word_t execute_instr(input in_word_t w);
    logic [31:0] lhs, rhs, lmag, rmag, quo;
    out_word_t   r;
    r = '0;
    lhs = reg_read(w.dest_reg);
    rhs = w.src_is_reg ? reg_read(w.src_reg) : w.immediate;
    case (action_t'(w.action))
      ACT_MOV: reg_write(w.dest_reg, rhs);
      ACT_INC: reg_write(w.dest_reg, lhs + 32'd1);
      ACT_DEC: reg_write(w.dest_reg, lhs - 32'd1);
      ACT_ADD: reg_write(w.dest_reg, lhs + rhs);
      ACT_SUB: reg_write(w.dest_reg, lhs - rhs);
      ACT_MUL: reg_write(w.dest_reg, lhs * rhs);
      ACT_DIV: begin
        if (rhs == 32'd0) begin
          r.divide_error = 1'b1;
        end else begin
          // magnitudes as unsigned, quotient truncates toward zero
          lmag = lhs[31] ? -lhs : lhs;
          rmag = rhs[31] ? -rhs : rhs;
          quo = lmag / rmag;
          if (lhs[31] ^ rhs[31]) quo = -quo;
          reg_write(w.dest_reg, quo);
        end
      end
      ACT_CMP: begin
        if (lhs == rhs) arch_cmp = CMP_EQ;
        else if ($signed(lhs) > $signed(rhs)) arch_cmp = CMP_GT;
        else arch_cmp = CMP_LT;
      end
      ACT_JMP: r.branch_taken = 1'b1;
      ACT_JNE: r.branch_taken = (arch_cmp != CMP_EQ);
      ACT_JE:  r.branch_taken = (arch_cmp == CMP_EQ);
      ACT_JGE: r.branch_taken = (arch_cmp == CMP_EQ) || (arch_cmp == CMP_GT);
      ACT_JG:  r.branch_taken = (arch_cmp == CMP_GT);
      ACT_JLE: r.branch_taken = (arch_cmp != CMP_GT);
      ACT_JL:  r.branch_taken = (arch_cmp != CMP_EQ) && (arch_cmp != CMP_GT);
      default: ;
    endcase
    if (w.action < ACT_JMP || w.action == ACT_READ) r.dest_value = reg_read(w.dest_reg);
    return r;
  endfunction

  function automatic void add_item(input action_t act, input logic [4:0] dst,
                                   input logic sreg, input logic [4:0] src,
                                   input logic [31:0] imm, input logic drain = 1'b0);
    instr_slot_t s;
    s.drain_first = drain;
    s.word.action = act;
    s.word.dest_reg = dst;
    s.word.src_is_reg = sreg;
    s.word.src_reg = src;
    s.word.immediate = imm;
    instr_queue.push_back(s);
  endfunction

  // mostly a few hot registers, sometimes an index past the file
  function automatic logic [4:0] pick_reg();
    case ($urandom_range(0, 15))
      0:       return $urandom_range(NUM_REGS, 31);
      1, 2, 3: return $urandom_range(0, NUM_REGS - 1);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return $urandom_range(0, 20) - 10;
      default: return $urandom();
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    action_t     act;
    logic [4:0]  dst, src;
    logic        sreg, drain;
    logic [31:0] imm;
    for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
    arch_cmp = CMP_EQ;

    // wrap on inc and dec
    add_item(ACT_MOV, 0, 0, 7, 32'h7FFF_FFFF);
    add_item(ACT_INC, 0, 1, 25, $urandom());
    add_item(ACT_DEC, 0, 0, 31, $urandom());
    // most negative over minus one, divide by zero, truncation
    add_item(ACT_MOV, 1, 0, 0, 32'h8000_0000);
    add_item(ACT_MOV, 2, 0, 0, 32'hFFFF_FFFF);
    add_item(ACT_DIV, 1, 1, 2, 32'd0);
    add_item(ACT_DIV, 0, 0, 5, 32'd0);
    add_item(ACT_DIV, 0, 1, 3, 32'h1234_5678);
    add_item(ACT_DIV, 0, 0, 0, 32'hFFFF_FFF9);
    // multiply and add/sub wrap
    add_item(ACT_MUL, 1, 1, 2, 32'd0);
    add_item(ACT_MUL, 0, 1, 0, 32'd0);
    add_item(ACT_ADD, 25, 1, 0, 32'd0);
    add_item(ACT_SUB, 24, 0, 0, 32'h8000_0000);
    // index past the register file
    add_item(ACT_MOV, 31, 0, 0, 32'd5);
    add_item(ACT_READ, 31, 1, 31, $urandom());
    add_item(ACT_ADD, 3, 1, 30, 32'd0);
    // every compare outcome and every jump
    add_item(ACT_CMP, 2, 0, 0, 32'h8000_0000);
    add_item(ACT_JG, $urandom_range(0, 31), 1, 4, $urandom());
    add_item(ACT_JGE, $urandom_range(0, 31), 0, 9, $urandom());
    add_item(ACT_JLE, $urandom_range(0, 31), 1, 31, $urandom());
    add_item(ACT_CMP, 1, 0, 0, 32'h7FFF_FFFF);
    add_item(ACT_JL, $urandom_range(0, 31), 0, 0, $urandom());
    add_item(ACT_JNE, $urandom_range(0, 31), 1, 17, $urandom());
    add_item(ACT_CMP, 25, 1, 25, 32'd0);
    add_item(ACT_JE, $urandom_range(0, 31), 0, 0, $urandom());
    add_item(ACT_JMP, $urandom_range(0, 31), 1, 12, $urandom());
    add_item(ACT_READ, 25, 0, 0, 32'hFFFF_FFFF);

    // random traffic, compares often followed by a jump
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      drain = (n == 120) || (n == 300);
      dst = pick_reg();
      src = pick_reg();
      sreg = $urandom_range(0, 1);
      imm = pick_imm();
      act = action_t'($urandom_range(0, 15));
      if (act == ACT_DIV && $urandom_range(0, 3) == 0) begin
        sreg = 1'b0;
        imm = '0;
      end
      if ($urandom_range(0, 5) == 0) begin
        add_item(ACT_CMP, dst, sreg, src, imm, drain);
        act = action_t'($urandom_range(ACT_JMP, ACT_JL));
        drain = 1'b0;
      end
      add_item(act, dst, sreg, src, imm, drain);
    end
    total_words = instr_queue.size();

    // checked at the rising edge, after the driver's updates have settled
    while (rst || instr_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // hold the offered word
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (instr_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if (instr_queue[0].drain_first && pending_results.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      in_data <= instr_queue[0].word;
      in_valid <= 1'b1;
      void'(instr_queue.pop_front());
      if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 14);
    end
  end

  // output ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // accept monitor, result checker and cycle limit
  always @(posedge clk) begin
    out_word_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        pending_results.push_back(execute_instr(in_data));
        words_in++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, actual value %0d taken %b div_err %b",
                   $time, out_data.dest_value, out_data.branch_taken,
                   out_data.divide_error);
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want) begin
            errors++;
            $display("%0t: mismatch expected value %0d taken %b div_err %b",
                     $time, want.dest_value, want.branch_taken, want.divide_error);
            $display("%0t:          actual   value %0d taken %b div_err %b",
                     $time, out_data.dest_value, out_data.branch_taken,
                     out_data.divide_error);
          end
        end
      end
    end
  end

endmodule
